[hdl/p2ba_pkg.sv]
package p2ba_pkg;

  localparam int MAX_CLASSES      = 11;
  localparam int DEF_COUNT_WIDTH  = 16;
  localparam int SIZE_W           = 11;
  localparam int FIELD_W          = 16;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              action;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic                   valid;
    logic                   err;
    logic [MAX_CLASSES-1:0] credit;
    logic [MAX_CLASSES-1:0] debit;
  } plan_t;

endpackage

[hdl/p2ba_cmd_reg.sv]
module p2ba_cmd_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic                      action,
  input  logic [p2ba_pkg::SIZE_W-1:0] request_size,
  output p2ba_pkg::cmd_t            cmd
);
  import p2ba_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd.valid <= 1'b0;
    end else begin
      cmd.valid <= take;
    end
    if (take) begin
      cmd.action <= action;
      cmd.size   <= request_size;
    end
  end

endmodule

[hdl/p2ba_plan.sv]
module p2ba_plan #(
  parameter int NUM_CLASSES = p2ba_pkg::MAX_CLASSES
) (
  input  p2ba_pkg::cmd_t         cmd,
  input  logic [NUM_CLASSES-1:0] nonzero,
  output p2ba_pkg::plan_t        plan
);
  import p2ba_pkg::*;

  logic [NUM_CLASSES-1:0] fit;
  logic [NUM_CLASSES-1:0] exact;
  logic [NUM_CLASSES-1:0] cand;
  logic [NUM_CLASSES-1:0] sel;
  logic [NUM_CLASSES-1:0] size_n;
  logic [NUM_CLASSES-1:0] low_oh;
  logic [NUM_CLASSES-1:0] below_sel;
  logic [NUM_CLASSES-1:0] above_low;
  logic [NUM_CLASSES-1:0] split_credit;
  logic [NUM_CLASSES-1:0] credit_n;
  logic [NUM_CLASSES-1:0] debit_n;
  logic                   hit;
  logic                   is_exact;
  logic                   err;

  genvar i;
  generate
    for (i = 0; i < NUM_CLASSES; i++) begin : g_cmp
      assign fit[i]   = (cmd.size <= (SIZE_W'(1) << i));
      assign exact[i] = (cmd.size == (SIZE_W'(1) << i));
    end
  endgenerate

  assign size_n       = cmd.size[NUM_CLASSES-1:0];
  assign cand         = nonzero & fit;
  assign sel          = cand & (~cand + NUM_CLASSES'(1));
  assign hit          = |cand;
  assign is_exact     = |(sel & exact);
  assign low_oh       = size_n & (~size_n + NUM_CLASSES'(1));
  assign below_sel    = sel - NUM_CLASSES'(1);
  assign above_low    = ~((low_oh - NUM_CLASSES'(1)) | low_oh);
  assign split_credit = below_sel & (low_oh | (above_low & ~size_n));

  always_comb begin
    credit_n = '0;
    debit_n  = '0;
    err      = 1'b0;
    priority if (!cmd.valid) begin
      err = 1'b0;
    end else if (cmd.action == ACT_RELEASE) begin
      credit_n = size_n;
    end else if (cmd.size == '0) begin
      err = 1'b0;
    end else if (!hit) begin
      err = 1'b1;
    end else if (is_exact) begin
      debit_n = sel;
    end else begin
      debit_n  = sel;
      credit_n = split_credit;
    end
  end

  assign plan.valid  = cmd.valid;
  assign plan.err    = err;
  assign plan.credit = MAX_CLASSES'(credit_n);
  assign plan.debit  = MAX_CLASSES'(debit_n);

endmodule

[hdl/p2ba_counters.sv]
module p2ba_counters #(
  parameter int NUM_CLASSES = p2ba_pkg::MAX_CLASSES,
  parameter int COUNT_WIDTH = p2ba_pkg::DEF_COUNT_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  p2ba_pkg::plan_t                         plan,
  output logic [NUM_CLASSES-1:0]                  nonzero,
  output logic [NUM_CLASSES-1:0][COUNT_WIDTH-1:0] cnt,
  output logic                                    done,
  output logic                                    alloc_error
);
  import p2ba_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

  logic [NUM_CLASSES-1:0][COUNT_WIDTH-1:0] cnt_next;
  logic [NUM_CLASSES-1:0]                  credit;
  logic [NUM_CLASSES-1:0]                  debit;

  assign credit = plan.credit[NUM_CLASSES-1:0];
  assign debit  = plan.debit[NUM_CLASSES-1:0];

  genvar i;
  generate
    for (i = 0; i < NUM_CLASSES; i++) begin : g_cnt
      assign nonzero[i] = (cnt[i] != '0);
      always_comb begin
        cnt_next[i] = cnt[i];
        if (credit[i] && !debit[i] && cnt[i] != CountMax) begin
          cnt_next[i] = cnt[i] + COUNT_WIDTH'(1);
        end else if (debit[i] && !credit[i] && cnt[i] != '0) begin
          cnt_next[i] = cnt[i] - COUNT_WIDTH'(1);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      done        <= 1'b0;
      alloc_error <= 1'b0;
    end else begin
      cnt         <= cnt_next;
      done        <= plan.valid;
      alloc_error <= plan.valid & plan.err;
    end
  end

`ifndef SYNTHESIS
  a_no_empty_debit: assert property (@(posedge clk) disable iff (rst)
    plan.valid |-> ((debit & ~nonzero) == '0))
    else $error("debit of an empty class");

  a_disjoint: assert property (@(posedge clk) disable iff (rst)
    plan.valid |-> ((credit & debit) == '0))
    else $error("class credited and debited at once");

  a_err_frozen: assert property (@(posedge clk) disable iff (rst)
    (plan.valid && plan.err) |=> $stable(cnt))
    else $error("counts changed on failed allocate");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    plan.valid |=> done)
    else $error("item lost its result strobe");

  a_err_strobed: assert property (@(posedge clk) disable iff (rst)
    alloc_error |-> done)
    else $error("error without result strobe");
`endif

endmodule

[hdl/power_of_two_block_allocator_unit.sv]
// power-of-two block allocator: counts of free blocks per size class 1..1024
// command channel: start, action, request_size; an item is taken at a clock
// edge where start is high and busy is low; busy is always low, so an item
// can be given in every cycle
// result channel: done strobes for one cycle with alloc_error and
// free_count_0..free_count_10; the receiver must take it in that cycle,
// there is no way to hold results off
// latency: an item taken at edge n has its result on the ports in the cycle
// after edge n+1 (done high), taken at edge n+2
// throughput: one item per cycle; the counter bank is updated from the
// registered item in a single cycle, so the next item sees the new counts
// release credits one block per set size bit; allocate takes an exact
// block or splits the smallest larger free class, or flags alloc_error
// and leaves the counts alone; counters saturate at their width
// reset (rst, synchronous): all counts zero, no item in flight, done low
module power_of_two_block_allocator_unit #(
  parameter int NUM_CLASSES = p2ba_pkg::MAX_CLASSES,
  parameter int COUNT_WIDTH = p2ba_pkg::DEF_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action,
  input  logic [p2ba_pkg::SIZE_W-1:0]    request_size,
  output logic                           done,
  output logic                           alloc_error,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_0,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_1,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_2,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_3,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_4,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_5,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_6,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_7,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_8,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_9,
  output logic [p2ba_pkg::FIELD_W-1:0]   free_count_10
);
  import p2ba_pkg::*;

  cmd_t                                    cmd;
  plan_t                                   plan;
  logic [NUM_CLASSES-1:0]                  nonzero;
  logic [NUM_CLASSES-1:0][COUNT_WIDTH-1:0] cnt;
  logic [MAX_CLASSES-1:0][FIELD_W-1:0]     fields;

  assign busy = 1'b0;

  p2ba_cmd_reg u_cmd (
    .clk          (clk),
    .rst          (rst),
    .take         (start & ~busy),
    .action       (action),
    .request_size (request_size),
    .cmd          (cmd)
  );

  p2ba_plan #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_plan (
    .cmd     (cmd),
    .nonzero (nonzero),
    .plan    (plan)
  );

  p2ba_counters #(
    .NUM_CLASSES (NUM_CLASSES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cnt (
    .clk         (clk),
    .rst         (rst),
    .plan        (plan),
    .nonzero     (nonzero),
    .cnt         (cnt),
    .done        (done),
    .alloc_error (alloc_error)
  );

  genvar i;
  generate
    for (i = 0; i < MAX_CLASSES; i++) begin : g_field
      if (i >= NUM_CLASSES) begin : g_none
        assign fields[i] = '0;
      end else if (COUNT_WIDTH >= FIELD_W) begin : g_trunc
        assign fields[i] = cnt[i][FIELD_W-1:0];
      end else begin : g_ext
        assign fields[i] = FIELD_W'(cnt[i]);
      end
    end
  endgenerate

  assign free_count_0  = fields[0];
  assign free_count_1  = fields[1];
  assign free_count_2  = fields[2];
  assign free_count_3  = fields[3];
  assign free_count_4  = fields[4];
  assign free_count_5  = fields[5];
  assign free_count_6  = fields[6];
  assign free_count_7  = fields[7];
  assign free_count_8  = fields[8];
  assign free_count_9  = fields[9];
  assign free_count_10 = fields[10];

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import p2ba_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_CAP     = 60;
  localparam logic [FIELD_W-1:0] COUNT_MAX = FIELD_W'((2 ** DEF_COUNT_WIDTH) - 1);
  localparam logic [SIZE_W-1:0]  ALL_SIZE_BITS = '1;

  typedef struct packed {
    logic                                err;
    logic [MAX_CLASSES-1:0][FIELD_W-1:0] counts;
  } alloc_result_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 action;
  logic [SIZE_W-1:0]    request_size;
  logic                 done;
  logic                 alloc_error;
  logic [FIELD_W-1:0]   free_count_0;
  logic [FIELD_W-1:0]   free_count_1;
  logic [FIELD_W-1:0]   free_count_2;
  logic [FIELD_W-1:0]   free_count_3;
  logic [FIELD_W-1:0]   free_count_4;
  logic [FIELD_W-1:0]   free_count_5;
  logic [FIELD_W-1:0]   free_count_6;
  logic [FIELD_W-1:0]   free_count_7;
  logic [FIELD_W-1:0]   free_count_8;
  logic [FIELD_W-1:0]   free_count_9;
  logic [FIELD_W-1:0]   free_count_10;

  logic [MAX_CLASSES-1:0][FIELD_W-1:0] dut_counts;

  logic [FIELD_W-1:0] free_blocks [MAX_CLASSES];
  alloc_result_t      pending_results [$];
  int                 mismatches;
  int                 stalled_cycles;
  bit                 pacing_on;

  assign dut_counts = {free_count_10, free_count_9, free_count_8, free_count_7,
                       free_count_6, free_count_5, free_count_4, free_count_3,
                       free_count_2, free_count_1, free_count_0};

  power_of_two_block_allocator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .request_size (request_size),
    .done         (done),
    .alloc_error  (alloc_error),
    .free_count_0 (free_count_0),
    .free_count_1 (free_count_1),
    .free_count_2 (free_count_2),
    .free_count_3 (free_count_3),
    .free_count_4 (free_count_4),
    .free_count_5 (free_count_5),
    .free_count_6 (free_count_6),
    .free_count_7 (free_count_7),
    .free_count_8 (free_count_8),
    .free_count_9 (free_count_9),
    .free_count_10(free_count_10)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void credit_class(input int cls);
    if (free_blocks[cls] != COUNT_MAX) free_blocks[cls] = free_blocks[cls] + 1'b1;
  endfunction

  // free counts after one request, updating the predicted counter bank
  function automatic alloc_result_t predict_counts(input logic act,
                                                   input logic [SIZE_W-1:0] size);
    alloc_result_t r;
    int split;
    int low;
    bit taken;
    r.err = 1'b0;
    split = -1;
    taken = 1'b0;
    if (act == ACT_RELEASE) begin
      for (int i = 0; i < MAX_CLASSES; i++) begin
        if (size[i]) credit_class(i);
      end
    end else if (size != '0) begin
      for (int i = 0; i < MAX_CLASSES && split < 0 && !taken; i++) begin
        if (free_blocks[i] != '0) begin
          if ((1 << i) == int'(size)) begin
            free_blocks[i] = free_blocks[i] - 1'b1;
            taken = 1'b1;
          end else if ((1 << i) > int'(size)) begin
            split = i;
          end
        end
      end
      if (!taken) begin
        if (split < 0) begin
          r.err = 1'b1;
        end else begin
          low = 0;
          while (low < split && !size[low]) low++;
          credit_class(low);
          for (int i = low + 1; i < split; i++) begin
            if (!size[i]) credit_class(i);
          end
          free_blocks[split] = free_blocks[split] - 1'b1;
        end
      end
    end
    for (int i = 0; i < MAX_CLASSES; i++) r.counts[i] = free_blocks[i];
    return r;
  endfunction

  task automatic hold_off(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_request(input logic act, input logic [SIZE_W-1:0] size);
    if (pacing_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
    start        = 1'b1;
    action       = act;
    request_size = size;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_counts(act, size));
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    mismatches++;
    if (mismatches <= REPORT_CAP) $error("%s expected %0d actual %0d", field, want, got);
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP) $error("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (alloc_error !== want.err) report_mismatch("alloc_error", want.err, alloc_error);
        for (int i = 0; i < MAX_CLASSES; i++) begin
          if (dut_counts[i] !== want.counts[i])
            report_mismatch($sformatf("free_count_%0d", i), want.counts[i], dut_counts[i]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_directed();
    pacing_on = 1'b1;
    issue_request(ACT_ALLOC, 11'd1);
    issue_request(ACT_ALLOC, ALL_SIZE_BITS);
    issue_request(ACT_RELEASE, ALL_SIZE_BITS);
    issue_request(ACT_ALLOC, 11'd1024);
    issue_request(ACT_ALLOC, 11'd1);
    issue_request(ACT_ALLOC, 11'd1025);
    issue_request(ACT_ALLOC, 11'd1024);
    issue_request(ACT_RELEASE, 11'd1024);
    issue_request(ACT_ALLOC, 11'd1000);
    issue_request(ACT_ALLOC, 11'd3);
    issue_request(ACT_RELEASE, 11'h555);
    issue_request(ACT_RELEASE, 11'h2AA);
    issue_request(ACT_ALLOC, 11'd513);
    issue_request(ACT_ALLOC, ALL_SIZE_BITS);
    issue_request(ACT_RELEASE, 11'd1536);
    issue_request(ACT_ALLOC, 11'd768);
    issue_request(ACT_ALLOC, 11'd1023);
    issue_request(ACT_ALLOC, 11'd2);
    issue_request(ACT_ALLOC, 11'd6);
    issue_request(ACT_RELEASE, 11'd1);
    issue_request(ACT_ALLOC, 11'd7);
  endtask

  task automatic test_drain_pause();
    pacing_on = 1'b0;
    issue_request(ACT_RELEASE, 11'd96);
    issue_request(ACT_ALLOC, 11'd40);
    issue_request(ACT_ALLOC, 11'd32);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    issue_request(ACT_ALLOC, 11'd5);
    issue_request(ACT_RELEASE, 11'd5);
  endtask

  task automatic test_random_mix();
    logic             act;
    logic [SIZE_W-1:0] size;
    int               pick;
    for (int seg = 0; seg < 19; seg++) begin
      pacing_on = (seg < 16) && ($urandom_range(0, 2) != 0);
      for (int n = 0; n < 100; n++) begin
        act  = ($urandom_range(0, 9) < 4) ? ACT_RELEASE : ACT_ALLOC;
        pick = $urandom_range(0, 9);
        if (pick < 3)      size = SIZE_W'(1 << $urandom_range(0, 10));
        else if (pick < 6) size = SIZE_W'($urandom_range(1, 64));
        else if (pick < 9) size = SIZE_W'($urandom_range(1, 2047));
        else               size = SIZE_W'($urandom_range(1025, 2047));
        issue_request(act, size);
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    action         = ACT_ALLOC;
    request_size   = '0;
    mismatches     = 0;
    stalled_cycles = 0;
    pacing_on      = 1'b0;
    for (int i = 0; i < MAX_CLASSES; i++) free_blocks[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_drain_pause();
    test_random_mix();

    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
